[rtl/core/tic_pkg.sv]
`default_nettype none

package tic_pkg;

    // Stage enables handed to the split multiplier
    typedef struct packed {
        logic pp;   // partial product stage
        logic sum;  // partial product sum stage
    } t_mul_en;

    // Result bit positions in the output word
    localparam int unsigned FLAG_CIRCLE = 0;
    localparam int unsigned FLAG_TRI    = 1;
    localparam int unsigned FLAG_DEGEN  = 2;
    localparam int unsigned OUT_BITS    = 8;

endpackage

`default_nettype wire

[rtl/core/tic_split_mul.sv]
`default_nettype none

module tic_split_mul #(
    parameter int OP_BITS = 34
) (
    input  wire logic                            i_clk,
    input  wire tic_pkg::t_mul_en                i_en,
    input  wire logic signed [OP_BITS-1:0]       i_a,
    input  wire logic signed [OP_BITS-1:0]       i_b,
    output logic signed [2*OP_BITS-1:0]          o_prod
);
    import tic_pkg::*;

    localparam int LO  = OP_BITS / 2;
    localparam int HI  = OP_BITS - LO;
    localparam int PPW = OP_BITS + 2;
    localparam int RW  = 2 * OP_BITS;

    logic signed [LO:0]     w_a_lo;
    logic signed [LO:0]     w_b_lo;
    logic signed [HI-1:0]   w_a_hi;
    logic signed [HI-1:0]   w_b_hi;
    logic signed [PPW-1:0]  r_pll;
    logic signed [PPW-1:0]  r_plh;
    logic signed [PPW-1:0]  r_phl;
    logic signed [PPW-1:0]  r_phh;
    logic signed [RW-1:0]   n_prod;
    logic signed [RW-1:0]   r_prod;

    // low halves are unsigned, high halves carry the sign
    assign w_a_lo = {1'b0, i_a[LO-1:0]};
    assign w_b_lo = {1'b0, i_b[LO-1:0]};
    assign w_a_hi = i_a[OP_BITS-1:LO];
    assign w_b_hi = i_b[OP_BITS-1:LO];

    // four half-width products
    always_ff @(posedge i_clk) begin
        if (i_en.pp) begin
            r_pll <= PPW'(w_a_lo) * PPW'(w_b_lo);
            r_plh <= PPW'(w_a_lo) * PPW'(w_b_hi);
            r_phl <= PPW'(w_a_hi) * PPW'(w_b_lo);
            r_phh <= PPW'(w_a_hi) * PPW'(w_b_hi);
        end
    end

    // weighted recombination
    always_comb begin
        n_prod = (RW'(r_phh) <<< (2 * LO)) + (RW'(r_plh) <<< LO)
               + (RW'(r_phl) <<< LO) + RW'(r_pll);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

[rtl/core/triangle_incircle_and_inside_test_top.sv]
// Incircle / point-in-triangle predicate pipeline.
// Each input word passes through the registered stages below before its result word is valid.
// Throughput: one word per cycle; each stage holds while the next one is full and stalled.
// Stage set by the 3x3 incircle determinant, built from split half-width multipliers.
// Reset (synchronous, active low) clears all stage valid bits; data registers are not reset.
`default_nettype none

module triangle_incircle_and_inside_test_top #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y, query_x, query_y
    input  wire logic [8*COORD_BITS-1:0]    i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    // inside_circle, inside_triangle, degenerate, zero fill
    output logic [7:0]                      o_m_axis_tdata
);
    import tic_pkg::*;

    localparam int N  = COORD_BITS;
    localparam int DW = N + 1;          // coordinate difference
    localparam int PW = 2 * N + 2;      // products, lifted lengths, minors
    localparam int OW = 2 * N + 4;      // orientation sum
    localparam int TW = 2 * PW;         // determinant term
    localparam int SW = TW + 2;         // determinant sum
    localparam int NS = 6;              // pipeline stages

    logic [NS-1:0]          r_vld;
    logic [NS-1:0]          w_en;

    logic signed [N-1:0]    w_c [8];
    logic signed [DW-1:0]   r_d [6];    // adx, ady, bdx, bdy, cdx, cdy
    logic signed [PW-1:0]   r_sq [6];
    logic signed [PW-1:0]   r_x [6];
    logic signed [PW-1:0]   r_l [3];    // la, lb, lc
    logic signed [PW-1:0]   r_m [3];    // mbc, mca, mab
    logic signed [TW-1:0]   w_t [3];
    logic signed [OW-1:0]   n_o;
    logic                   n_tri_ok;
    logic                   r3_o_pos, r3_o_neg, r3_tri_ok;
    logic                   r4_o_pos, r4_o_neg, r4_tri_ok;
    logic signed [SW-1:0]   n_det;
    logic                   r_circle, r_tri, r_degen;
    t_mul_en                w_mul_en;

    // stage i may load when empty or when its word moves on
    always_comb begin
        w_en[NS-1] = ~r_vld[NS-1] | i_m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = ~r_vld[k] | w_en[k+1];
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_vld[NS-1];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // unpack coordinates
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_c[k] = i_s_axis_tdata[k*N +: N];
        end
    end

    // stage 0: vertices relative to the query point
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int k = 0; k < 6; k++) begin
                r_d[k] <= DW'(w_c[k]) - DW'(w_c[6 + (k % 2)]);
            end
        end
    end

    // stage 1: squares and cross products
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int k = 0; k < 6; k++) begin
                r_sq[k] <= PW'(r_d[k]) * PW'(r_d[k]);
            end
            r_x[0] <= PW'(r_d[2]) * PW'(r_d[5]);
            r_x[1] <= PW'(r_d[4]) * PW'(r_d[3]);
            r_x[2] <= PW'(r_d[4]) * PW'(r_d[1]);
            r_x[3] <= PW'(r_d[0]) * PW'(r_d[5]);
            r_x[4] <= PW'(r_d[0]) * PW'(r_d[3]);
            r_x[5] <= PW'(r_d[2]) * PW'(r_d[1]);
        end
    end

    // stage 2: lifted lengths and 2x2 minors
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int k = 0; k < 3; k++) begin
                r_l[k] <= r_sq[2*k] + r_sq[2*k+1];
                r_m[k] <= r_x[2*k] - r_x[2*k+1];
            end
        end
    end

    // stage 3: orientation is the sum of the minors; minors are the sub-areas
    always_comb begin
        n_o = OW'(r_m[0]) + OW'(r_m[1]) + OW'(r_m[2]);
        n_tri_ok = (~n_o[OW-1] & (n_o != '0)
                    & ~r_m[0][PW-1] & ~r_m[1][PW-1] & ~r_m[2][PW-1])
                 | (n_o[OW-1]
                    & (r_m[0][PW-1] | (r_m[0] == '0))
                    & (r_m[1][PW-1] | (r_m[1] == '0))
                    & (r_m[2][PW-1] | (r_m[2] == '0)));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_o_pos  <= ~n_o[OW-1] & (n_o != '0);
            r3_o_neg  <= n_o[OW-1];
            r3_tri_ok <= n_tri_ok;
        end
    end

    // stage 4: flags ride along with the multiplier sums
    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_o_pos  <= r3_o_pos;
            r4_o_neg  <= r3_o_neg;
            r4_tri_ok <= r3_tri_ok;
        end
    end

    assign w_mul_en.pp  = w_en[3];
    assign w_mul_en.sum = w_en[4];

    // determinant terms: la*mbc, lb*mca, lc*mab
    for (genvar g = 0; g < 3; g++) begin : g_term
        tic_split_mul #(
            .OP_BITS (PW)
        ) u_mul (
            .i_clk  (i_clk),
            .i_en   (w_mul_en),
            .i_a    (r_l[g]),
            .i_b    (r_m[g]),
            .o_prod (w_t[g])
        );
    end

    // stage 5: determinant sign against orientation, output register
    always_comb begin
        n_det = SW'(w_t[0]) + SW'(w_t[1]) + SW'(w_t[2]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_circle <= (r4_o_pos & ~n_det[SW-1] & (n_det != '0))
                      | (r4_o_neg & n_det[SW-1]);
            r_tri    <= r4_tri_ok;
            r_degen  <= ~r4_o_pos & ~r4_o_neg;
        end
    end

    always_comb begin
        o_m_axis_tdata              = '0;
        o_m_axis_tdata[FLAG_CIRCLE] = r_circle;
        o_m_axis_tdata[FLAG_TRI]    = r_tri;
        o_m_axis_tdata[FLAG_DEGEN]  = r_degen;
    end

    // degenerate word never claims containment
    a_degen_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[FLAG_DEGEN])
            |-> (!o_m_axis_tdata[FLAG_CIRCLE] && !o_m_axis_tdata[FLAG_TRI]))
        else $error("degenerate result with containment flag set");

    // a free output lets the whole pipe move
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input stalled while output is free");

    // a word in the middle stage that cannot advance stays put
    a_hold_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && !w_en[4]) |=> r_vld[3])
        else $error("word lost in stage 3");

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tic_pkg::*;

    localparam int COORD_BITS   = 16;
    localparam int WORD_BITS    = 8 * COORD_BITS;
    localparam int RANDOM_WORDS = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT_WORD = 200;
    localparam int DRAIN_CYCLES = 12;   // pipeline is 6 deep, plus margin
    localparam int MAX_PRINTS   = 20;

    // one result word, laid out as on o_m_axis_tdata
    typedef struct packed {
        logic [4:0] fill;
        logic       degenerate;
        logic       inside_triangle;
        logic       inside_circle;
    } tri_flags_t;

    // directed stimulus row: input word, plus a hand-typed answer where obvious
    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 typed;
        tri_flags_t           flags;
    } dir_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [WORD_BITS-1:0]  i_s_axis_tdata;   // a_x, a_y, b_x, b_y, c_x, c_y, q_x, q_y
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [7:0]            o_m_axis_tdata;   // inside_circle, inside_triangle, degenerate, fill

    tri_flags_t flags_due_q[$];
    dir_row_t   dir_q[$];

    int errors;
    int words_sent;
    int results_seen;
    int n_circle, n_tri, n_degen;
    int backpressure_cycles;
    int burst_left;
    int hold_left;
    bit hold_done;

    triangle_incircle_and_inside_test_top #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1ms;
        $display("triangle_incircle_and_inside_test_top verification failed");
        $finish;
    end

    function automatic logic [WORD_BITS-1:0] pack_item(int ax, int ay, int bx, int by,
                                                       int cx, int cy, int px, int py);
        return {COORD_BITS'(py), COORD_BITS'(px), COORD_BITS'(cy), COORD_BITS'(cx),
                COORD_BITS'(by), COORD_BITS'(bx), COORD_BITS'(ay), COORD_BITS'(ax)};
    endfunction

    function automatic dir_row_t mk_row(int ax, int ay, int bx, int by, int cx, int cy,
                                        int px, int py, bit typed, bit ci, bit tr, bit dg);
        dir_row_t r;
        r.word  = pack_item(ax, ay, bx, by, cx, cy, px, py);
        r.typed = typed;
        r.flags = '{fill: 5'd0, degenerate: dg, inside_triangle: tr, inside_circle: ci};
        return r;
    endfunction

    // Exact incircle / point-in-triangle flags from determinant signs
    function automatic tri_flags_t predict_flags(logic [WORD_BITS-1:0] w);
        longint c[8];
        longint orient_abc, s1, s2, s3;
        longint adx, ady, bdx, bdy, cdx, cdy;
        logic signed [127:0] la, lb, lc, mbc, mca, mab, det;
        tri_flags_t f;
        for (int k = 0; k < 8; k++)
            c[k] = longint'($signed(w[k*COORD_BITS +: COORD_BITS]));
        f = '0;
        orient_abc = (c[2] - c[0]) * (c[5] - c[1]) - (c[3] - c[1]) * (c[4] - c[0]);
        if (orient_abc == 0) begin
            f.degenerate = 1'b1;
        end else begin
            adx = c[0] - c[6];  ady = c[1] - c[7];
            bdx = c[2] - c[6];  bdy = c[3] - c[7];
            cdx = c[4] - c[6];  cdy = c[5] - c[7];
            la  = adx * adx + ady * ady;
            lb  = bdx * bdx + bdy * bdy;
            lc  = cdx * cdx + cdy * cdy;
            mbc = bdx * cdy - cdx * bdy;
            mca = cdx * ady - adx * cdy;
            mab = adx * bdy - bdx * ady;
            det = la * mbc + lb * mca + lc * mab;
            // same sign as the winding means strictly inside, either orientation
            f.inside_circle = (det != 0) && ((det < 0) == (orient_abc < 0));
            s1 = (c[2] - c[6]) * (c[5] - c[7]) - (c[3] - c[7]) * (c[4] - c[6]);
            s2 = (c[6] - c[0]) * (c[5] - c[1]) - (c[7] - c[1]) * (c[4] - c[0]);
            s3 = (c[2] - c[0]) * (c[7] - c[1]) - (c[3] - c[1]) * (c[6] - c[0]);
            if (orient_abc > 0)
                f.inside_triangle = (s1 >= 0) && (s2 >= 0) && (s3 >= 0);
            else
                f.inside_triangle = (s1 <= 0) && (s2 <= 0) && (s3 <= 0);
        end
        return f;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 6))
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return 32766;
            default: return 32767;
        endcase
    endfunction

    // Random triangle/query word, mostly shaped to hit edges, circles and collinear cases
    function automatic logic [WORD_BITS-1:0] random_item();
        int v[8];
        int bx0, by0, k, j, jn, x0, x1, y0, y1, t;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                for (int i = 0; i < 8; i++) v[i] = int'($urandom_range(0, 65535)) - 32768;
            end
            3, 4: begin
                // tight cluster: frequent collinear, on-edge and cocircular hits
                bx0 = int'($urandom_range(0, 65503)) - 32752;
                by0 = int'($urandom_range(0, 65503)) - 32752;
                for (int i = 0; i < 8; i += 2) begin
                    v[i]   = bx0 + int'($urandom_range(0, 16)) - 8;
                    v[i+1] = by0 + int'($urandom_range(0, 16)) - 8;
                end
            end
            5: begin
                // collinear vertices
                for (int i = 0; i < 4; i++) v[i] = int'($urandom_range(0, 10000)) - 5000;
                k = int'($urandom_range(0, 4)) - 2;
                v[4] = v[0] + k * (v[2] - v[0]);
                v[5] = v[1] + k * (v[3] - v[1]);
                v[6] = int'($urandom_range(0, 65535)) - 32768;
                v[7] = int'($urandom_range(0, 65535)) - 32768;
            end
            6: begin
                // query on a vertex or at an edge midpoint (even coords keep it exact)
                for (int i = 0; i < 6; i++) v[i] = 2 * (int'($urandom_range(0, 20000)) - 10000);
                j  = $urandom_range(0, 2);
                jn = (j + 1) % 3;
                if ($urandom_range(0, 1)) begin
                    v[6] = v[2*j];
                    v[7] = v[2*j+1];
                end else begin
                    v[6] = (v[2*j] + v[2*jn]) / 2;
                    v[7] = (v[2*j+1] + v[2*jn+1]) / 2;
                end
            end
            7: begin
                // rectangle corners: query lies exactly on the circumcircle
                x0 = int'($urandom_range(0, 65535)) - 32768;
                x1 = int'($urandom_range(0, 65535)) - 32768;
                y0 = int'($urandom_range(0, 65535)) - 32768;
                y1 = int'($urandom_range(0, 65535)) - 32768;
                v = '{x0, y0, x1, y0, x1, y1, x0, y1};
                if ($urandom_range(0, 1)) begin
                    t = v[2]; v[2] = v[4]; v[4] = t;
                    t = v[3]; v[3] = v[5]; v[5] = t;
                end
            end
            8: begin
                for (int i = 0; i < 8; i++) v[i] = pick_extreme();
            end
            default: begin
                // query near the centroid
                for (int i = 0; i < 6; i++) v[i] = int'($urandom_range(0, 65535)) - 32768;
                v[6] = (v[0] + v[2] + v[4]) / 3;
                v[7] = (v[1] + v[3] + v[5]) / 3;
            end
        endcase
        return pack_item(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    endfunction

    task automatic flag_mismatch(input string what, input int got_v, input int want_v);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("MISMATCH result %0d %s: got %0d want %0d", results_seen, what,
                     got_v, want_v);
    endtask

    // Offer one word until taken, then queue its expected flags
    task automatic send_word(input logic [WORD_BITS-1:0] w, input bit typed,
                             input tri_flags_t typed_flags);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= w;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        flags_due_q.push_back(typed ? typed_flags : predict_flags(w));
        words_sent++;
        @(negedge i_clk);
    endtask

    // Burst/gap pacing of the sender
    task automatic pace();
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                i_s_axis_tvalid <= 1'b0;
                i_s_axis_tdata  <= {$urandom, $urandom, $urandom, $urandom};
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end
    endtask

    // Receiver: ready pattern is picked at random among five modes, one long hold-off mid-run
    initial begin
        int rx_cyc;
        int rx_mode;
        i_m_axis_tready = 1'b0;
        rx_cyc    = 0;
        rx_mode   = 0;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            rx_cyc++;
            if (rx_cyc % 50 == 0) rx_mode = $urandom_range(0, 4);
            if (!hold_done && words_sent >= HOLD_AT_WORD) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       i_m_axis_tready <= 1'b1;
                    1:       i_m_axis_tready <= $urandom_range(0, 1);
                    2:       i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                    3:       i_m_axis_tready <= ($urandom_range(0, 9) != 0);
                    default: i_m_axis_tready <= rx_cyc[0];
                endcase
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        tri_flags_t got, want;
        if (i_rst_n && hold_left > 0 && i_s_axis_tvalid && !o_s_axis_tready)
            backpressure_cycles++;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.inside_circle   = o_m_axis_tdata[FLAG_CIRCLE];
            got.inside_triangle = o_m_axis_tdata[FLAG_TRI];
            got.degenerate      = o_m_axis_tdata[FLAG_DEGEN];
            got.fill            = o_m_axis_tdata[OUT_BITS-1:3];
            n_circle += got.inside_circle;
            n_tri    += got.inside_triangle;
            n_degen  += got.degenerate;
            if (flags_due_q.size() == 0) begin
                flag_mismatch("word with nothing outstanding", o_m_axis_tdata, 0);
            end else begin
                want = flags_due_q.pop_front();
                if (got.inside_circle !== want.inside_circle)
                    flag_mismatch("inside_circle", got.inside_circle, want.inside_circle);
                if (got.inside_triangle !== want.inside_triangle)
                    flag_mismatch("inside_triangle", got.inside_triangle,
                                  want.inside_triangle);
                if (got.degenerate !== want.degenerate)
                    flag_mismatch("degenerate", got.degenerate, want.degenerate);
                if (got.fill !== want.fill)
                    flag_mismatch("zero fill", got.fill, want.fill);
            end
            results_seen++;
        end
    end

    // Main sequence
    initial begin
        errors              = 0;
        words_sent          = 0;
        results_seen        = 0;
        n_circle            = 0;
        n_tri               = 0;
        n_degen             = 0;
        backpressure_cycles = 0;
        i_rst_n             = 1'b0;
        i_s_axis_tvalid     = 1'b0;
        i_s_axis_tdata      = '0;

        //                   ax      ay      bx      by      cx      cy      px      py
        // degenerate: all at origin, collinear diagonal, all min, all max
        dir_q.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1));
        dir_q.push_back(mk_row(-32768, -32768, 32767, 32767, 0, 0, 5, -5, 1, 0, 0, 1));
        dir_q.push_back(mk_row(-32768, -32768, -32768, -32768, -32768, -32768,
                               -32768, -32768, 1, 0, 0, 1));
        dir_q.push_back(mk_row(32767, 32767, 32767, 32767, 32767, 32767,
                               32767, 32767, 1, 0, 0, 1));
        // full-range right triangle: query at a vertex, at the far corner, just past the hypotenuse
        dir_q.push_back(mk_row(-32768, -32768, 32767, -32768, -32768, 32767,
                               -32768, -32768, 1, 0, 1, 0));
        dir_q.push_back(mk_row(-32768, -32768, 32767, -32768, -32768, 32767,
                               32767, 32767, 1, 0, 0, 0));
        dir_q.push_back(mk_row(-32768, -32768, 32767, -32768, -32768, 32767,
                               0, 0, 0, 0, 0, 0));
        // same triangle, clockwise, query on an edge
        dir_q.push_back(mk_row(-32768, -32768, -32768, 32767, 32767, -32768,
                               -32768, 0, 0, 0, 0, 0));
        // small right triangle, counterclockwise
        dir_q.push_back(mk_row(0, 0, 4, 0, 0, 4, 1, 1, 1, 1, 1, 0));
        dir_q.push_back(mk_row(0, 0, 4, 0, 0, 4, 2, 0, 1, 1, 1, 0));
        dir_q.push_back(mk_row(0, 0, 4, 0, 0, 4, 4, 4, 1, 0, 0, 0));
        dir_q.push_back(mk_row(0, 0, 4, 0, 0, 4, 3, 3, 1, 1, 0, 0));
        dir_q.push_back(mk_row(0, 0, 4, 0, 0, 4, 10, 10, 1, 0, 0, 0));
        dir_q.push_back(mk_row(0, 0, 4, 0, 0, 4, 4, 0, 1, 0, 1, 0));
        dir_q.push_back(mk_row(0, 0, 4, 0, 0, 4, -32768, 32767, 1, 0, 0, 0));
        // small right triangle, clockwise
        dir_q.push_back(mk_row(0, 0, 0, 4, 4, 0, 1, 1, 1, 1, 1, 0));
        dir_q.push_back(mk_row(0, 0, 0, 4, 4, 0, 4, 4, 1, 0, 0, 0));
        // query at circumcenter, on the hypotenuse
        dir_q.push_back(mk_row(-1, -1, 1, -1, -1, 1, 0, 0, 1, 1, 1, 0));
        // mixed extremes, alternating bit patterns, very thin triangle
        dir_q.push_back(mk_row(32767, -32768, -32768, 32767, 32767, 32767,
                               -1, -1, 0, 0, 0, 0));
        dir_q.push_back(mk_row(21845, -21846, -21846, 21845, 21845, 21845,
                               -21846, -21846, 0, 0, 0, 0));
        dir_q.push_back(mk_row(-32768, -32768, 32767, 32766, 0, 0, 1, 1, 0, 0, 0, 0));

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        burst_left = $urandom_range(1, 24);
        foreach (dir_q[i]) begin
            send_word(dir_q[i].word, dir_q[i].typed, dir_q[i].flags);
            pace();
        end
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            send_word(random_item(), 1'b0, '0);
            pace();
        end
        i_s_axis_tvalid <= 1'b0;

        while (flags_due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d words (%0d directed), %0d results: circle %0d, triangle %0d, degenerate %0d",
                 words_sent, dir_q.size(), results_seen, n_circle, n_tri, n_degen);
        $display("Input held off %0d cycles during the long output stall", backpressure_cycles);
        if (errors == 0) begin
            $display("triangle_incircle_and_inside_test_top verification clean");
        end else begin
            $display("triangle_incircle_and_inside_test_top verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
